>>> design/ach_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ach_pkg
// shared constants, types and the arctangent table for the compass heading
// ----------------------------------------------------------------------------
package ach_pkg;

    localparam int AVG_COUNT_DEF = 10;
    localparam int HEADING_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int SUM_W = 21;
    localparam int VEC_W = 38;
    localparam int ANG_W = 28;
    localparam int HEAD_W = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_AVG,
        ST_MULT,
        ST_PREP,
        ST_ROT,
        ST_FIN,
        ST_OUT
    } t_state;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (i)
                5'd0:  v = 28'sd2949120;
                5'd1:  v = 28'sd1740967;
                5'd2:  v = 28'sd919879;
                5'd3:  v = 28'sd466945;
                5'd4:  v = 28'sd234379;
                5'd5:  v = 28'sd117304;
                5'd6:  v = 28'sd58666;
                5'd7:  v = 28'sd29335;
                5'd8:  v = 28'sd14668;
                5'd9:  v = 28'sd7334;
                5'd10: v = 28'sd3667;
                5'd11: v = 28'sd1833;
                5'd12: v = 28'sd917;
                5'd13: v = 28'sd458;
                5'd14: v = 28'sd229;
                5'd15: v = 28'sd115;
                5'd16: v = 28'sd57;
                5'd17: v = 28'sd29;
                5'd18: v = 28'sd14;
                5'd19: v = 28'sd7;
                5'd20: v = 28'sd4;
                5'd21: v = 28'sd2;
                5'd22: v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/ach_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ach channel interfaces
// valid/ready channels for samples, headings and register writes
// ----------------------------------------------------------------------------
interface ach_sample_if;
    logic valid;
    logic ready;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    modport source (output valid, output mag_x, output mag_y, input ready);
    modport sink (input valid, input mag_x, input mag_y, output ready);
endinterface

interface ach_heading_if;
    logic valid;
    logic ready;
    logic [14:0] heading_deg;
    logic cal_error;
    modport source (output valid, output heading_deg, output cal_error, input ready);
    modport sink (input valid, input heading_deg, input cal_error, output ready);
endinterface

interface ach_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/averaged_compass_heading_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// averaged_compass_heading_top
// averages ten samples, applies hard-iron calibration, cordic heading
// ----------------------------------------------------------------------------
// sequence: a sample that completes an average passes the states DIV, AVG, MULT,
//   PREP, ROT (one rotation per cordic step) and FIN before its heading is valid
//   (others only add); throughput: one sample per cycle while averaging; the
//   completing sample holds the input off while the single shared cordic
//   add/shift unit works and until its heading is taken
// reset: synchronous active low; sums, count and calibration to reset values
module averaged_compass_heading_top
    import ach_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF,
    parameter int HEADING_FRAC_BITS = HEADING_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input wire i_clk,
    input wire i_rst_n,
    ach_sample_if.sink i_sample,
    ach_heading_if.source o_heading,
    ach_cfg_if.sink i_cfg
);
    localparam int CNT_W = 5;
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int DROP = 16 - HEADING_FRAC_BITS;
    localparam int FULL = 360 << HEADING_FRAC_BITS;
    localparam int RECIP_SH = 24;
    localparam longint RECIP = ((longint'(1) << RECIP_SH) + AVG_COUNT - 1) / AVG_COUNT;
    localparam int PROD_W = 35;

    t_state r_state, n_state;
    logic signed [15:0] r_max_x, r_min_x, r_max_y, r_min_y;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [CNT_W-1:0] r_count;
    logic signed [VEC_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [ANG_W-1:0] r_z, n_z;
    logic [4:0] r_step, n_step;
    logic signed [SUM_W-1:0] r_avx, r_avy;
    logic signed [17:0] r_nx, r_ny;
    logic signed [16:0] r_spx, r_spy;
    logic r_err, r_zero;
    logic [HEAD_W-1:0] r_head, n_head;
    logic r_oval;

    logic acc;
    logic signed [SUM_W-1:0] nsx, nsy;
    logic [SUM_W-1:0] abs_x, abs_y;
    logic [SUM_W+RECIP_SH:0] qpx, qpy;
    logic signed [SUM_W-1:0] avx, avy;
    logic signed [PROD_W-1:0] px, py;
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [ANG_W:0] zr;
    logic [ANG_W:0] hr;

    assign i_sample.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign acc = i_sample.valid && i_sample.ready;
    assign nsx = r_sum_x + SUM_W'(i_sample.mag_x);
    assign nsy = r_sum_y + SUM_W'(i_sample.mag_y);
    // divide by the average count through a reciprocal, truncating toward zero
    assign abs_x = r_sum_x[SUM_W-1] ? $unsigned(-r_sum_x) : $unsigned(r_sum_x);
    assign abs_y = r_sum_y[SUM_W-1] ? $unsigned(-r_sum_y) : $unsigned(r_sum_y);
    assign qpx = abs_x * (RECIP_SH+1)'(RECIP);
    assign qpy = abs_y * (RECIP_SH+1)'(RECIP);
    assign avx = r_sum_x[SUM_W-1] ? -$signed(qpx[RECIP_SH +: SUM_W])
                                  : $signed(qpx[RECIP_SH +: SUM_W]);
    assign avy = r_sum_y[SUM_W-1] ? -$signed(qpy[RECIP_SH +: SUM_W])
                                  : $signed(qpy[RECIP_SH +: SUM_W]);
    assign px = r_nx * r_spy;
    assign py = r_ny * r_spx;
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;
    assign zr = (r_z < 0) ? (ANG_W+1)'(r_z) + (ANG_W+1)'(360 * 65536)
                          : (ANG_W+1)'(r_z);
    assign o_heading.valid = r_oval;
    assign o_heading.heading_deg = r_head;
    assign o_heading.cal_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= -16'sd102;
            r_min_x <= -16'sd307;
            r_max_y <= 16'sd501;
            r_min_y <= 16'sd250;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_X: r_max_x <= i_cfg.data;
                REG_MIN_X: r_min_x <= i_cfg.data;
                REG_MAX_Y: r_max_y <= i_cfg.data;
                REG_MIN_Y: r_min_y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_sum_x <= nsx;
                r_sum_y <= nsy;
                r_count <= (32'(r_count) + 1 >= AVG_COUNT) ? '0 : r_count + 1'b1;
            end
            if (r_state == ST_DIV) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
            end
            if (r_state == ST_FIN) r_oval <= 1'b1;
            else if (o_heading.ready) r_oval <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_step <= n_step;
        r_head <= n_head;
        if (r_state == ST_DIV) begin
            r_avx <= avx;
            r_avy <= avy;
        end
        if (r_state == ST_AVG) begin
            r_nx <= 18'(2 * 32'(r_avx)) - 18'(r_min_x) - 18'(r_max_x);
            r_ny <= 18'(2 * 32'(r_avy)) - 18'(r_min_y) - 18'(r_max_y);
            r_spx <= 17'(r_max_x) - 17'(r_min_x);
            r_spy <= 17'(r_max_y) - 17'(r_min_y);
        end
        if (r_state == ST_MULT) begin
            r_err <= (r_spx <= 0) || (r_spy <= 0);
        end
        if (r_state == ST_PREP) r_zero <= (r_x == 0) && (r_y == 0);
    end

    always_comb begin
        n_state = r_state;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_step = r_step;
        n_head = r_head;
        hr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && (32'(r_count) + 1 >= AVG_COUNT)) n_state = ST_DIV;
            end
            ST_DIV: n_state = ST_AVG;
            ST_AVG: n_state = ST_MULT;
            ST_MULT: begin
                n_x = VEC_W'(px);
                n_y = VEC_W'(py);
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_step = '0;
                if (r_x < 0) begin
                    n_x = -r_x;
                    n_y = -r_y;
                    n_z = ANG_W'(180 * 65536);
                end else begin
                    n_z = '0;
                end
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (r_y > 0) begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atan_entry(r_step);
                end else begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atan_entry(r_step);
                end
                n_step = r_step + 1'b1;
                if (32'(r_step) == STEPS - 1) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (DROP > 0) hr = ($unsigned(zr) + (ANG_W+1)'(1 << (DROP - 1))) >> DROP;
                else hr = $unsigned(zr);
                if (hr >= (ANG_W+1)'(FULL)) hr = hr - (ANG_W+1)'(FULL);
                n_head = (r_err || r_zero) ? '0 : HEAD_W'(hr);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_heading.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> !r_oval)
        else $error("sample taken while heading pending");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_oval && r_state == ST_OUT))
        else $error("heading not raised after cordic");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> (32'(r_head) < FULL))
        else $error("heading out of range");
endmodule
`default_nettype wire
